>>> rtl/sfr_pkg.sv
// sfr_pkg: shared types and codes for the stuffed frame receiver.
// Used by sfr_step and stuffed_frame_receiver; depends on nothing.
package sfr_pkg;

    // header search phases
    localparam logic [1:0] PHASE_WAIT_FF  = 2'd0;
    localparam logic [1:0] PHASE_WAIT_00  = 2'd1;
    localparam logic [1:0] PHASE_WAIT_LEN = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
    localparam logic [1:0] KIND_GOOD      = 2'd1;
    localparam logic [1:0] KIND_BAD       = 2'd2;
    localparam logic [1:0] KIND_ABANDONED = 2'd3;

    // header bytes
    localparam logic [7:0] HDR_FIRST  = 8'hFF;
    localparam logic [7:0] HDR_SECOND = 8'h00;

    typedef struct packed {
        logic [1:0] phase;
        logic [7:0] frame_length;
        logic [7:0] bytes_received;
        logic [7:0] running_sum;
    } sfr_state_t;

    typedef struct packed {
        logic [7:0] byte_index;
        logic [7:0] byte_value;
        logic [1:0] kind;
    } sfr_result_t;

endpackage

>>> rtl/sfr_step.sv
// sfr_step: per-byte update of the frame receiver state and its result.
// Purely combinational; depends on sfr_pkg.
module sfr_step
(
    input  sfr_pkg::sfr_state_t  state,
    input  logic [7:0]           rx_byte,
    output sfr_pkg::sfr_state_t  state_next,
    output logic                 result_valid,
    output sfr_pkg::sfr_result_t result
);

    logic hdr_start;
    logic hdr_guard;
    logic frame_active;

    always_comb
    begin
        hdr_start = 1'b0;
        hdr_guard = 1'b0;
        state_next = state;
        unique case (state.phase)
            sfr_pkg::PHASE_WAIT_00:
            begin
                if (rx_byte == sfr_pkg::HDR_SECOND)
                begin
                    state_next.phase = sfr_pkg::PHASE_WAIT_LEN;
                end
                else if (rx_byte != sfr_pkg::HDR_FIRST)
                begin
                    state_next.phase = sfr_pkg::PHASE_WAIT_FF;
                end
            end
            sfr_pkg::PHASE_WAIT_LEN:
            begin
                state_next.phase = sfr_pkg::PHASE_WAIT_FF;
                hdr_guard = (rx_byte == 8'd0);
                hdr_start = (rx_byte != 8'd0);
            end
            default:
            begin
                state_next.phase = (rx_byte == sfr_pkg::HDR_FIRST) ?
                                   sfr_pkg::PHASE_WAIT_00 : sfr_pkg::PHASE_WAIT_FF;
            end
        endcase

        frame_active      = (state.frame_length != 8'd0);
        result_valid      = 1'b0;
        result.kind       = sfr_pkg::KIND_PAYLOAD;
        result.byte_value = rx_byte;
        result.byte_index = state.frame_length;

        if (hdr_guard)
        begin
            // stuffing guard: dropped
        end
        else if (hdr_start)
        begin
            result_valid              = frame_active;
            result.kind               = sfr_pkg::KIND_ABANDONED;
            state_next.frame_length   = rx_byte;
            state_next.bytes_received = 8'd0;
            state_next.running_sum    = 8'd0;
        end
        else if (frame_active)
        begin
            result_valid = 1'b1;
            if (state.bytes_received < state.frame_length)
            begin
                result.kind               = sfr_pkg::KIND_PAYLOAD;
                result.byte_index         = state.bytes_received;
                state_next.running_sum    = state.running_sum + rx_byte;
                state_next.bytes_received = state.bytes_received + 8'd1;
            end
            else
            begin
                result.kind = (rx_byte == ~state.running_sum) ?
                              sfr_pkg::KIND_GOOD : sfr_pkg::KIND_BAD;
                state_next.frame_length = 8'd0;
            end
        end
    end

endmodule

>>> rtl/stuffed_frame_receiver.sv
// stuffed_frame_receiver: top level of the byte-stuffed serial frame receiver.
// Depends on sfr_pkg and sfr_step.
//
//  channel   | direction | tdata                                   | tuser
//  s_axis    | in        | [7:0] rx_byte                           | -
//  m_axis    | out       | [7:0] byte_value, [15:8] byte_index     | [1:0] result_kind
//
// One byte per cycle sustained while results are taken. A byte waits in the input
// register, then the step logic updates the frame state and loads the result register.
// The result passes the input register and then the result register before it is valid.
// Bytes that give no result (guards, idle line, headers) still move on each cycle unless stalled.
// Reset returns the header search to its start with no frame open.
// A stalled result stalls the input register; tready drops only when both hold items.
module stuffed_frame_receiver
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] byte_value, [15:8] byte_index
    output logic [1:0]  m_axis_tuser    // [1:0] result_kind
);

    // input register
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;

    // frame state
    sfr_pkg::sfr_state_t state_reg;
    sfr_pkg::sfr_state_t state_next;

    // result register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    sfr_pkg::sfr_result_t out_reg;

    sfr_pkg::sfr_result_t step_result;
    logic                 step_valid;
    logic                 advance;
    logic                 in_take;

    sfr_step u_step
    (
        .state        (state_reg),
        .rx_byte      (in_byte_reg),
        .state_next   (state_next),
        .result_valid (step_valid),
        .result       (step_result)
    );

    // the held byte is processed once the result register can take its result
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = step_valid;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            state_reg.phase          <= sfr_pkg::PHASE_WAIT_FF;
            state_reg.frame_length   <= 8'd0;
            state_reg.bytes_received <= 8'd0;
            state_reg.running_sum    <= 8'd0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (advance && step_valid)
        begin
            out_reg <= step_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.byte_index, out_reg.byte_value};
    assign m_axis_tuser  = out_reg.kind;

endmodule

>>> tb/sv/tb.sv
// tb: self-checking testbench for stuffed_frame_receiver.
// Drives framed byte streams, predicts every result and compares field by field.
// Depends on sfr_pkg and the stuffed_frame_receiver RTL.
module tb;

    localparam int ITEMS         = 1100;   // stimulus stops once this many bytes are queued
    localparam int IDLE_PCT      = 8;      // chance in a hundred of an idle cycle, each side
    localparam int SETTLE_CYCLES = 6;      // pipeline is two deep; a little margin on top
    localparam int TAIL_CYCLES   = 20;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int CALM_FROM     = 400;    // window with no idling on either side
    localparam int CALM_TO       = 800;
    localparam int PAUSE_MARK    = 600;    // sender drains the pipe once past this many bytes
    localparam logic [7:0] GUARD_BYTE = 8'h00;

    // header search outcome for one byte
    typedef enum logic [1:0] {SCAN_PASS, SCAN_LENGTH, SCAN_GUARD} scan_t;

    // payload patterns for built frames
    typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_STUFF} fill_t;

    // one byte on the line; drain holds the sender until nothing is outstanding
    typedef struct {
        logic [7:0] rx;
        bit         drain;
    } line_item_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;     // [7:0] byte_value, [15:8] byte_index
    logic [1:0]  m_axis_tuser;     // [1:0] result_kind

    line_item_t           line_q[$];        // bytes still to be sent
    sfr_pkg::sfr_result_t results_due[$];   // predicted results, oldest first
    sfr_pkg::sfr_state_t  rx_state;         // predictor's copy of the frame state
    int          mismatches = 0;
    int          cycle_count = 0;
    int          settle_left;
    logic        sender_done;
    logic        calm;

    // builder state
    bit          after_ff;
    bit          pause_next;

    stuffed_frame_receiver uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

    task automatic report_mismatch(input string what);
        $display("[%0d] mismatch: %s", cycle_count, what);
        mismatches++;
    endtask

    // Advance the frame state by one received byte. Returns 1 when the byte
    // produces a result, which is then placed in res.
    function automatic bit frame_step(input logic [7:0] b, output sfr_pkg::sfr_result_t res);
        scan_t scan;
        scan = SCAN_PASS;
        res  = '0;
        // header search sees every byte, payload included
        case (rx_state.phase)
            sfr_pkg::PHASE_WAIT_00:
            begin
                if (b == sfr_pkg::HDR_SECOND)
                    rx_state.phase = sfr_pkg::PHASE_WAIT_LEN;
                else if (b != sfr_pkg::HDR_FIRST)
                    rx_state.phase = sfr_pkg::PHASE_WAIT_FF;
            end
            sfr_pkg::PHASE_WAIT_LEN:
            begin
                rx_state.phase = sfr_pkg::PHASE_WAIT_FF;
                scan = (b == GUARD_BYTE) ? SCAN_GUARD : SCAN_LENGTH;
            end
            default:
                rx_state.phase = (b == sfr_pkg::HDR_FIRST) ?
                                 sfr_pkg::PHASE_WAIT_00 : sfr_pkg::PHASE_WAIT_FF;
        endcase

        if (scan == SCAN_GUARD)
            return 1'b0;

        if (scan == SCAN_LENGTH)
        begin
            // a length byte opens a frame; one still open is abandoned
            frame_step = (rx_state.frame_length != 8'd0);
            res.kind       = sfr_pkg::KIND_ABANDONED;
            res.byte_value = b;
            res.byte_index = rx_state.frame_length;
            rx_state.frame_length   = b;
            rx_state.bytes_received = 8'd0;
            rx_state.running_sum    = 8'd0;
            return frame_step;
        end

        if (rx_state.frame_length == 8'd0)
            return 1'b0;

        if (rx_state.bytes_received < rx_state.frame_length)
        begin
            res.kind       = sfr_pkg::KIND_PAYLOAD;
            res.byte_value = b;
            res.byte_index = rx_state.bytes_received;
            rx_state.running_sum    = rx_state.running_sum + b;
            rx_state.bytes_received = rx_state.bytes_received + 8'd1;
        end
        else
        begin
            // checksum byte closes the frame
            res.kind       = (b == ~rx_state.running_sum) ?
                             sfr_pkg::KIND_GOOD : sfr_pkg::KIND_BAD;
            res.byte_value = b;
            res.byte_index = rx_state.frame_length;
            rx_state.frame_length = 8'd0;
        end
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Stream builder
    // ---------------------------------------------------------------

    task automatic put_raw(input logic [7:0] b);
        line_item_t it;
        it.rx      = b;
        it.drain   = pause_next;
        pause_next = 1'b0;
        line_q.push_back(it);
    endtask

    // payload or checksum byte: a guard follows any FF 00 so it is not read as a header
    task automatic put_payload(input logic [7:0] b);
        put_raw(b);
        if (after_ff && b == sfr_pkg::HDR_SECOND)
        begin
            put_raw(GUARD_BYTE);
            after_ff = 1'b0;
        end
        else
            after_ff = (b == sfr_pkg::HDR_FIRST);
    endtask

    task automatic open_frame(input logic [7:0] len);
        put_raw(sfr_pkg::HDR_FIRST);
        put_raw(sfr_pkg::HDR_SECOND);
        put_raw(len);
        after_ff = 1'b0;
    endtask

    task automatic send_frame(input int len, input fill_t fill, input bit good);
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] check;
        sum = 8'd0;
        open_frame(len[7:0]);
        for (int i = 0; i < len; i++)
        begin
            case (fill)
                FILL_ZERO:  b = 8'h00;
                FILL_ONES:  b = 8'hFF;
                FILL_STUFF: b = (i % 2 == 0) ? sfr_pkg::HDR_FIRST : sfr_pkg::HDR_SECOND;
                default:    b = 8'($urandom_range(0, 255));
            endcase
            put_payload(b);
            sum = sum + b;
        end
        check = ~sum;
        if (!good)
            check = check ^ 8'($urandom_range(1, 255));
        put_payload(check);
    endtask

    // ---------------------------------------------------------------
    // Driver: offers queued bytes, predicts each one as it is taken
    // ---------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin : feed
        sfr_pkg::sfr_result_t res;
        line_item_t  head;
        logic        hold;
        logic        go;
        if (!rst_n)
        begin
            s_axis_tvalid  <= 1'b0;
            s_axis_tdata   <= 8'h00;
            sender_done    <= 1'b0;
            rx_state.phase          = sfr_pkg::PHASE_WAIT_FF;
            rx_state.frame_length   = 8'd0;
            rx_state.bytes_received = 8'd0;
            rx_state.running_sum    = 8'd0;
            settle_left             = SETTLE_CYCLES;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (frame_step(s_axis_tdata, res))
                    results_due.push_back(res);
            end

            // an offered byte stays put until taken
            hold = s_axis_tvalid && !s_axis_tready;
            go   = 1'b0;
            if (!hold && line_q.size() != 0)
            begin
                if (line_q[0].drain)
                begin
                    // wait for every result, then let the pipe empty of silent bytes
                    if (results_due.size() != 0)
                        settle_left = SETTLE_CYCLES;
                    else if (settle_left != 0)
                        settle_left--;
                    else
                        line_q[0].drain = 1'b0;
                end
                else
                    go = calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end

            if (go)
            begin
                head = line_q.pop_front();
                s_axis_tdata <= head.rx;
                settle_left   = SETTLE_CYCLES;
            end
            if (!hold)
                s_axis_tvalid <= go;
            sender_done <= (line_q.size() == 0) && !(hold || go);
        end
    end

    // ---------------------------------------------------------------
    // Monitor: checks each result against the oldest prediction
    // ---------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin : observe
        sfr_pkg::sfr_result_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (results_due.size() == 0)
                    report_mismatch($sformatf("unexpected result kind %0d value %02h index %0d",
                                              m_axis_tuser, m_axis_tdata[7:0],
                                              m_axis_tdata[15:8]));
                else
                begin
                    want = results_due.pop_front();
                    if (m_axis_tuser != want.kind)
                        report_mismatch($sformatf("result_kind %0d, expected %0d",
                                                  m_axis_tuser, want.kind));
                    if (m_axis_tdata[7:0] != want.byte_value)
                        report_mismatch($sformatf("byte_value %02h, expected %02h",
                                                  m_axis_tdata[7:0], want.byte_value));
                    if (m_axis_tdata[15:8] != want.byte_index)
                        report_mismatch($sformatf("byte_index %0d, expected %0d",
                                                  m_axis_tdata[15:8], want.byte_index));
                end
            end
            m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------

    initial
    begin
        int   pick;
        int   len;
        int   cut;
        bit   paused;
        rst_n      = 1'b0;
        after_ff   = 1'b0;
        pause_next = 1'b0;
        paused     = 1'b0;

        // directed part
        put_raw(8'h5A);                     // line noise, no frame open
        put_raw(sfr_pkg::HDR_FIRST);        // FF 00 00: guard with nothing open
        put_raw(sfr_pkg::HDR_SECOND);
        put_raw(GUARD_BYTE);
        put_raw(sfr_pkg::HDR_FIRST);        // extra FF before the header
        send_frame(1, FILL_ZERO, 1'b1);     // shortest frame, all-zero payload
        send_frame(2, FILL_ONES, 1'b1);     // all-ones payload
        send_frame(4, FILL_STUFF, 1'b1);    // FF 00 inside payload, guards inserted
        send_frame(3, FILL_RANDOM, 1'b0);   // checksum wrong
        open_frame(8'd5);                   // frame cut short by a new header
        put_payload(8'hAA);
        put_payload(8'h11);
        send_frame(1, FILL_RANDOM, 1'b1);

        // longest frame, length byte FF
        send_frame(255, FILL_RANDOM, 1'b1);

        // random part: mostly good frames, some noise and broken sequences
        while (line_q.size() < ITEMS)
        begin
            if (!paused && line_q.size() > PAUSE_MARK)
            begin
                pause_next = 1'b1;
                paused     = 1'b1;
            end
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            if (pick < 72)
                send_frame(len, FILL_RANDOM, $urandom_range(0, 9) != 0);
            else if (pick < 82)
            begin
                repeat ($urandom_range(1, 4))
                    put_raw(8'($urandom_range(0, 255)));
                after_ff = 1'b0;
            end
            else if (pick < 92)
            begin
                // header and part of the payload only; the next header abandons it
                cut = $urandom_range(0, len - 1);
                open_frame(len[7:0]);
                repeat (cut)
                    put_payload(8'($urandom_range(0, 255)));
            end
            else
            begin
                put_raw(sfr_pkg::HDR_FIRST);
                put_raw(sfr_pkg::HDR_SECOND);
                put_raw(GUARD_BYTE);
                after_ff = 1'b0;
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (!sender_done || line_q.size() != 0)
            @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (results_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", results_due.size()));

        if (mismatches == 0)
            $display("stuffed_frame_receiver test passed");
        else
            $display("stuffed_frame_receiver test failed");
        $finish;
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("stuffed_frame_receiver test failed");
        $finish;
    end

endmodule
